### hdl/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared types, constants and helpers of the flow depth triangulation block.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int FLOW_BITS  = 24;
  localparam int FLOW_FRAC  = 8;
  localparam int VAL_W      = 32;
  localparam int DEPTH_W    = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = 48;
  localparam int WIDE_W     = 64;
  localparam int SAT_IN_W   = 72;
  localparam int QUO_BITS   = DEPTH_W;
  localparam int REM_W      = WIDE_W + QUO_BITS + 1;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAT_R0     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_R0R1   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_R1     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_R2     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_R2B1   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_B23   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH  = 4'd7;

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(64'sd2147483647);

  typedef struct packed {
    logic [COORD_BITS-1:0]       pixel_x;
    logic [COORD_BITS-1:0]       pixel_y;
    logic signed [FLOW_BITS-1:0] flow_dx;
    logic signed [FLOW_BITS-1:0] flow_dy;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_out;
    logic               denom_zero;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] m00, m01, m02;
    logic signed [VAL_W-1:0] m10, m11, m12;
    logic signed [VAL_W-1:0] m20, m21, m22;
    logic signed [VAL_W-1:0] b1, b2, b3;
    logic [DEPTH_W-1:0]      depth_lo;
    logic [DEPTH_W-1:0]      depth_hi;
  } cfg_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] num;
    logic [WIDE_W-1:0]        den;
  } mid_item_t;

  typedef struct packed {
    logic dz;
    logic npos;
    logic ovf;
  } div_flag_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] r;
    r = v;
    if (v > SAT_MAX) begin
      r = SAT_MAX;
    end else if (v < -SAT_MAX) begin
      r = -SAT_MAX;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

### hdl/fdt_regs.sv
// ----------------------------------------------------------------------------
// fdt_regs
// Configuration register file: matrix, baseline and depth clamps.
// ----------------------------------------------------------------------------
module fdt_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [fdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdt_pkg::CFG_DATA_W-1:0] cfg_data,
  output fdt_pkg::cfg_t                  cfg
);
  import fdt_pkg::*;

  logic [CFG_DATA_W-1:0] r0, r1, r2, r3, r4, r5;
  logic [DEPTH_W-1:0]    rmin, rmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0 <= '0; r1 <= '0; r2 <= '0; r3 <= '0; r4 <= '0; r5 <= '0;
      rmin <= '0;
      rmax <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAT_R0:    r0 <= cfg_data;
        REG_MAT_R0R1:  r1 <= cfg_data;
        REG_MAT_R1:    r2 <= cfg_data;
        REG_MAT_R2:    r3 <= cfg_data;
        REG_MAT_R2B1:  r4 <= cfg_data;
        REG_BASE_B23:  r5 <= cfg_data;
        REG_MIN_DEPTH: rmin <= cfg_data[DEPTH_W-1:0];
        REG_MAX_DEPTH: rmax <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.m00 = r0[31:0];  cfg.m01 = r0[63:32];
    cfg.m02 = r1[31:0];  cfg.m10 = r1[63:32];
    cfg.m11 = r2[31:0];  cfg.m12 = r2[63:32];
    cfg.m20 = r3[31:0];  cfg.m21 = r3[63:32];
    cfg.m22 = r4[31:0];  cfg.b1  = r4[63:32];
    cfg.b2  = r5[31:0];  cfg.b3  = r5[63:32];
    cfg.depth_lo = rmin;
    cfg.depth_hi = rmax;
  end

endmodule

### hdl/fdt_front.sv
// ----------------------------------------------------------------------------
// fdt_front
// Six-stage pipeline forming the numerator and denominator of the depth fit.
// ----------------------------------------------------------------------------
module fdt_front (
  input  logic                clk,
  input  logic                rst,
  input  fdt_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  fdt_pkg::in_item_t   item,
  output logic                mid_push,
  input  logic                mid_full,
  output fdt_pkg::mid_item_t  mid_item
);
  import fdt_pkg::*;

  logic [6:1] v;
  logic       en;

  logic signed [VAL_W-1:0]  a1_s1, a2_s1;
  logic signed [PROD_W-1:0] p00, p01, p10, p11, p20, p21;
  logic signed [VAL_W-1:0]  a1_s2, a2_s2, w1_s2, w2_s2, w3_s2;
  logic signed [VAL_W-1:0]  w1_s3, w2_s3;
  logic signed [WIDE_W-1:0] q1, q2, t1, t2;
  logic signed [VAL_W-1:0]  e1, e2, r1, r2;
  logic signed [WIDE_W-1:0] n1, n2, d1, d2;
  logic signed [WIDE_W-1:0] num;
  logic [WIDE_W-1:0]        den;

  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PROD_W-1:0]   p00_c, p01_c, p10_c, p11_c, p20_c, p21_c;
  logic signed [WIDE_W-1:0]   q1_c, q2_c, t1_c, t2_c, n1_c, n2_c, d1_c, d2_c;

  assign en       = !v[6] || !mid_full;
  assign full     = !en;
  assign mid_push = v[6] && en;
  assign mid_item = '{num: num, den: den};

  assign xs = $signed({1'b0, item.pixel_x});
  assign ys = $signed({1'b0, item.pixel_y});

  always_comb begin
    p00_c = PROD_W'(cfg.m00) * PROD_W'(xs);  p01_c = PROD_W'(cfg.m01) * PROD_W'(ys);
    p10_c = PROD_W'(cfg.m10) * PROD_W'(xs);  p11_c = PROD_W'(cfg.m11) * PROD_W'(ys);
    p20_c = PROD_W'(cfg.m20) * PROD_W'(xs);  p21_c = PROD_W'(cfg.m21) * PROD_W'(ys);
    q1_c = WIDE_W'(a1_s2) * WIDE_W'(w3_s2);  q2_c = WIDE_W'(a2_s2) * WIDE_W'(w3_s2);
    t1_c = WIDE_W'(a1_s2) * WIDE_W'(cfg.b3); t2_c = WIDE_W'(a2_s2) * WIDE_W'(cfg.b3);
    n1_c = WIDE_W'(r1) * WIDE_W'(e1);        n2_c = WIDE_W'(r2) * WIDE_W'(e2);
    d1_c = WIDE_W'(e1) * WIDE_W'(e1);        d2_c = WIDE_W'(e2) * WIDE_W'(e2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // flowed position and matrix products
      a1_s1 <= sat32((SAT_IN_W'(xs) <<< FRAC_BITS)
                     + (SAT_IN_W'(item.flow_dx) <<< (FRAC_BITS - FLOW_FRAC)));
      a2_s1 <= sat32((SAT_IN_W'(ys) <<< FRAC_BITS)
                     + (SAT_IN_W'(item.flow_dy) <<< (FRAC_BITS - FLOW_FRAC)));
      p00 <= p00_c; p01 <= p01_c; p10 <= p10_c;
      p11 <= p11_c; p20 <= p20_c; p21 <= p21_c;
      // rotated ray
      a1_s2 <= a1_s1;
      a2_s2 <= a2_s1;
      w1_s2 <= sat32(SAT_IN_W'(p00) + SAT_IN_W'(p01) + SAT_IN_W'(cfg.m02));
      w2_s2 <= sat32(SAT_IN_W'(p10) + SAT_IN_W'(p11) + SAT_IN_W'(cfg.m12));
      w3_s2 <= sat32(SAT_IN_W'(p20) + SAT_IN_W'(p21) + SAT_IN_W'(cfg.m22));
      // cross products with the third component
      w1_s3 <= w1_s2;
      w2_s3 <= w2_s2;
      q1 <= q1_c; q2 <= q2_c; t1 <= t1_c; t2 <= t2_c;
      // residual terms, arithmetic shift is a floor
      e1 <= sat32(SAT_IN_W'(w1_s3) - (SAT_IN_W'(q1) >>> FRAC_BITS));
      e2 <= sat32(SAT_IN_W'(w2_s3) - (SAT_IN_W'(q2) >>> FRAC_BITS));
      r1 <= sat32((SAT_IN_W'(t1) >>> FRAC_BITS) - SAT_IN_W'(cfg.b1));
      r2 <= sat32((SAT_IN_W'(t2) >>> FRAC_BITS) - SAT_IN_W'(cfg.b2));
      n1 <= n1_c; n2 <= n2_c; d1 <= d1_c; d2 <= d2_c;
      num <= n1 + n2;
      den <= WIDE_W'($unsigned(d1)) + WIDE_W'($unsigned(d2));
    end
  end

endmodule

### hdl/fdt_midq.sv
// ----------------------------------------------------------------------------
// fdt_midq
// Short queue between the front pipeline and the divider.
// ----------------------------------------------------------------------------
module fdt_midq (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  fdt_pkg::mid_item_t  wr_item,
  output logic                q_full,
  input  logic                rd,
  output logic                q_empty,
  output fdt_pkg::mid_item_t  rd_item
);
  import fdt_pkg::*;

  mid_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wp, rp;
  logic [Q_CNT_W-1:0]   cnt;

  assign q_full  = (cnt == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (cnt == '0);
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + Q_CNT_W'(wr) - Q_CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_item;
  end

endmodule

### hdl/fdt_back.sv
// ----------------------------------------------------------------------------
// fdt_back
// Pipelined restoring divider, one quotient bit a stage, then depth clamp
// and the result queue.
// ----------------------------------------------------------------------------
module fdt_back (
  input  logic                clk,
  input  logic                rst,
  input  fdt_pkg::cfg_t       cfg,
  input  logic                mid_empty,
  input  fdt_pkg::mid_item_t  mid_item,
  output logic                mid_pop,
  output logic                empty,
  input  logic                pop,
  output fdt_pkg::out_item_t  result
);
  import fdt_pkg::*;

  logic [QUO_BITS:0]     v;
  logic [REM_W-1:0]      rem  [QUO_BITS+1];
  logic [WIDE_W-1:0]     dd   [QUO_BITS+1];
  logic [QUO_BITS-1:0]   quo  [QUO_BITS+1];
  div_flag_t             flg  [QUO_BITS+1];
  logic                  en;

  out_item_t             oq [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wp, rp;
  logic [Q_CNT_W-1:0]    cnt;
  logic                  oq_full, oq_wr, oq_rd;
  out_item_t             fin;
  logic [DEPTH_W-1:0]    zc;
  logic [REM_W-1:0]      n_ext;

  assign oq_full = (cnt == Q_CNT_W'(Q_DEPTH));
  assign en      = !v[QUO_BITS] || !oq_full;
  assign mid_pop = en && !mid_empty;
  assign oq_wr   = en && v[QUO_BITS];
  assign empty   = (cnt == '0);
  assign oq_rd   = pop && !empty;
  assign result  = oq[rp];
  assign n_ext   = REM_W'($unsigned(mid_item.num)) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QUO_BITS-1:0], mid_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]      <= n_ext;
      dd[0]       <= mid_item.den;
      quo[0]      <= '0;
      flg[0].dz   <= (mid_item.den == '0);
      flg[0].npos <= (mid_item.num > 0);
      // quotient would need more than the result width
      flg[0].ovf  <= (n_ext >= (REM_W'(mid_item.den) << QUO_BITS));
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    localparam int BIT = QUO_BITS - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(dd[k]) << BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[k+1]  <= dd[k];
        flg[k+1] <= flg[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          quo[k+1] <= quo[k] | (QUO_BITS'(1) << BIT);
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  always_comb begin
    div_flag_t f;
    f  = flg[QUO_BITS];
    zc = '0;
    if (!f.dz && f.npos && !f.ovf) zc = quo[QUO_BITS];
    if (zc < cfg.depth_lo) zc = cfg.depth_lo;
    if (zc > cfg.depth_hi) zc = cfg.depth_hi;
    // saturated quotient always lands on the upper clamp
    if (f.npos && (f.dz || f.ovf)) zc = cfg.depth_hi;
    fin.depth_out  = zc;
    fin.denom_zero = f.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (oq_wr) wp <= wp + 1'b1;
      if (oq_rd) rp <= rp + 1'b1;
      cnt <= cnt + Q_CNT_W'(oq_wr) - Q_CNT_W'(oq_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) oq[wp] <= fin;
  end

endmodule

### hdl/flow_depth_triangulation.sv
// ----------------------------------------------------------------------------
// flow_depth_triangulation
// Per-pixel depth from optical flow by closed-form triangulation.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle unless a full queue stalls it, every stage
// including the 31 divider steps takes a new beat each cycle
// the front pipeline and divider stall independently around a 4-beat queue
// reset: synchronous, clears all queues and valids, config registers to zero
// except the upper depth clamp which resets to all ones
module flow_depth_triangulation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  fdt_pkg::in_item_t              item,
  output logic                           empty,
  input  logic                           pop,
  output fdt_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdt_pkg::*;

  cfg_t      cfg;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_wr, mid_rd;

  assign cfg_ready = 1'b1;

  fdt_regs u_regs (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .cfg
  );

  fdt_front u_front (
    .clk, .rst, .cfg, .push, .full, .item,
    .mid_push, .mid_full, .mid_item(mid_wr)
  );

  fdt_midq u_midq (
    .clk, .rst, .wr(mid_push), .wr_item(mid_wr), .q_full(mid_full),
    .rd(mid_pop), .q_empty(mid_empty), .rd_item(mid_rd)
  );

  fdt_back u_back (
    .clk, .rst, .cfg, .mid_empty, .mid_item(mid_rd), .mid_pop,
    .empty, .pop, .result
  );

endmodule

### hdl/fdt_checker.sv
// ----------------------------------------------------------------------------
// fdt_checker
// Port-level checks on the flow depth triangulation block.
// ----------------------------------------------------------------------------
module fdt_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input fdt_pkg::out_item_t result
);
  import fdt_pkg::*;

  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pending != 8'd0)
    else $error("result shown with no pixel outstanding");

  a_idle_not_full: assert property (@(posedge clk) disable iff (rst)
    pending == 8'd0 |-> !full)
    else $error("input blocked while block is idle");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

endmodule

bind flow_depth_triangulation fdt_checker u_fdt_checker (
  .clk, .rst, .push, .full, .empty, .pop, .result
);

### sim/flow_depth_triangulation_test.sv
// ----------------------------------------------------------------------------
// flow_depth_triangulation_test
// Streams pixels with flow through the depth block under several matrix,
// baseline and clamp settings, predicts each depth beat in fixed point and
// compares it with what the block returns, with random stalls on both sides.
// ----------------------------------------------------------------------------
module flow_depth_triangulation_test;
  import fdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SETTLE_CYCLES = 48;
  localparam int  HOLD_CYCLES   = 300;
  localparam int  STALL_LIMIT   = 3000;
  localparam longint CLIP       = 64'sd2147483647;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t geom;
  out_item_t depth_queue[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit sender_gaps = 1'b1;
  int idle_cycles = 0;

  flow_depth_triangulation dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip31(longint v);
    if (v > CLIP) return CLIP;
    if (v < -CLIP) return -CLIP;
    return v;
  endfunction

  function automatic out_item_t predict_depth(in_item_t px);
    longint x, y, fdx, fdy, a1, a2, w1, w2, w3, e1, e2, r1, r2, num;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, b1, b2, b3;
    logic [127:0] den, z, q, rem, nu;
    out_item_t o;
    m00 = longint'(geom.m00); m01 = longint'(geom.m01); m02 = longint'(geom.m02);
    m10 = longint'(geom.m10); m11 = longint'(geom.m11); m12 = longint'(geom.m12);
    m20 = longint'(geom.m20); m21 = longint'(geom.m21); m22 = longint'(geom.m22);
    b1 = longint'(geom.b1); b2 = longint'(geom.b2); b3 = longint'(geom.b3);
    x = longint'(px.pixel_x);
    y = longint'(px.pixel_y);
    fdx = longint'(px.flow_dx);
    fdy = longint'(px.flow_dy);
    a1 = clip31((x <<< FRAC_BITS) + (fdx <<< (FRAC_BITS - FLOW_FRAC)));
    a2 = clip31((y <<< FRAC_BITS) + (fdy <<< (FRAC_BITS - FLOW_FRAC)));
    w1 = clip31(m00 * x + m01 * y + m02);
    w2 = clip31(m10 * x + m11 * y + m12);
    w3 = clip31(m20 * x + m21 * y + m22);
    e1 = clip31(w1 - ((a1 * w3) >>> FRAC_BITS));
    e2 = clip31(w2 - ((a2 * w3) >>> FRAC_BITS));
    r1 = clip31(((a1 * b3) >>> FRAC_BITS) - b1);
    r2 = clip31(((a2 * b3) >>> FRAC_BITS) - b2);
    num = r1 * e1 + r2 * e2;
    den = 128'(64'(e1 * e1)) + 128'(64'(e2 * e2));
    o.denom_zero = (den == 128'd0);
    if (den == 128'd0) begin
      z = (num > 0) ? (128'd1 << 56) : 128'd0;
    end else if (num <= 0) begin
      z = 128'd0;
    end else begin
      nu = 128'(num);
      q = nu / den;
      rem = nu % den;
      if (q > (128'd1 << 31)) q = 128'd1 << 31;
      z = (q << FRAC_BITS) | ((rem << FRAC_BITS) / den);
    end
    if (z < 128'(geom.depth_lo)) z = 128'(geom.depth_lo);
    if (z > 128'(geom.depth_hi)) z = 128'(geom.depth_hi);
    o.depth_out = z[DEPTH_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint expd, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, expd, got, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (depth_queue.size() == 0) begin
        report_mismatch("unexpected beat", 0, result.depth_out);
      end else begin
        want = depth_queue.pop_front();
        if (result.depth_out !== want.depth_out)
          report_mismatch("depth_out", want.depth_out, result.depth_out);
        if (result.denom_zero !== want.denom_zero)
          report_mismatch("denom_zero", want.denom_zero, result.denom_zero);
      end
    end
  end

  // receiver with random stall bursts and one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(in_item_t px);
    @(negedge clk);
    push <= 1'b1;
    item <= px;
    do @(posedge clk); while (full);
    depth_queue.push_back(predict_depth(px));
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (depth_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAT_R0:    {geom.m01, geom.m00} = data;
      REG_MAT_R0R1:  {geom.m10, geom.m02} = data;
      REG_MAT_R1:    {geom.m12, geom.m11} = data;
      REG_MAT_R2:    {geom.m21, geom.m20} = data;
      REG_MAT_R2B1:  {geom.b1, geom.m22} = data;
      REG_BASE_B23:  {geom.b3, geom.b2} = data;
      REG_MIN_DEPTH: geom.depth_lo = data[DEPTH_W-1:0];
      REG_MAX_DEPTH: geom.depth_hi = data[DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // idle the block fully before touching registers
  task automatic settle();
    pause_sender(1);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_all(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                          logic [63:0] r3, logic [63:0] r4, logic [63:0] r5,
                          logic [63:0] lo, logic [63:0] hi);
    settle();
    write_reg(REG_MAT_R0, r0);
    write_reg(REG_MAT_R0R1, r1);
    write_reg(REG_MAT_R1, r2);
    write_reg(REG_MAT_R2, r3);
    write_reg(REG_MAT_R2B1, r4);
    write_reg(REG_BASE_B23, r5);
    write_reg(REG_MIN_DEPTH, lo);
    write_reg(REG_MAX_DEPTH, hi);
  endtask

  function automatic logic [31:0] near(int centre, int spread);
    return 32'(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // camera-like rotation and baseline, or raw random bits (upper clamp apart) when wild
  task automatic random_geometry(bit wild);
    logic [63:0] lo, hi;
    lo = $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(0, 32'h0010_0000));
    hi = $urandom_range(0, 3) == 0 ? 64'h7FFF_FFFF : 64'($urandom) & 64'h7FFF_FFFF;
    if (wild) begin
      load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, hi);
    end else begin
      load_all({near(0, 4000), near(65536, 4000)},
               {near(0, 4000), near(0, 200000)},
               {near(0, 200000), near(65536, 4000)},
               {near(0, 20), near(0, 20)},
               {near(0, 1 << 22), near(65536, 4000)},
               {near(0, 1 << 16), near(0, 1 << 22)}, lo, hi);
    end
  endtask

  function automatic in_item_t random_pixel();
    in_item_t p;
    p.pixel_x = COORD_BITS'($urandom);
    p.pixel_y = COORD_BITS'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.flow_dx = FLOW_BITS'($urandom);
      p.flow_dy = FLOW_BITS'($urandom);
    end else begin
      p.flow_dx = FLOW_BITS'(near(0, 1 << 14));
      p.flow_dy = FLOW_BITS'(near(0, 1 << 14));
    end
    return p;
  endfunction

  task automatic stream_pixels(int n);
    repeat (n) begin
      if (sender_gaps && !quiet && $urandom_range(0, 7) == 0)
        pause_sender($urandom_range(1, 13));
      send_pixel(random_pixel());
    end
  endtask

  task automatic test_reset_values();
    in_item_t p;
    p = '{pixel_x: 12'd100, pixel_y: 12'd200, flow_dx: 24'sd256, flow_dy: -24'sd256};
    send_pixel(p);
    send_pixel('0);
  endtask

  task automatic test_directed();
    in_item_t corner[8];
    corner[0] = '{12'd0, 12'd0, 24'sd0, 24'sd0};
    corner[1] = '{12'hFFF, 12'hFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    corner[2] = '{12'hFFF, 12'd0, 24'sh800000, 24'sh800000};
    corner[3] = '{12'd0, 12'hFFF, 24'sh7FFFFF, 24'sh800000};
    corner[4] = '{12'd640, 12'd360, 24'sd1280, -24'sd640};
    corner[5] = '{12'd1, 12'd1, -24'sd256, -24'sd256};
    corner[6] = '{12'hAAA, 12'h555, 24'shAAAAAA, 24'sh555555};
    corner[7] = '{12'h555, 12'hAAA, 24'sh555555, 24'shAAAAAA};
    // identity rotation, sideways baseline
    load_all({32'd0, 32'd65536}, {32'd0, 32'd0}, {32'd0, 32'd65536}, 64'd0,
             {32'd655360, 32'd65536}, {32'd65536, 32'd0}, 64'd0, 64'h7FFF_FFFF);
    foreach (corner[i]) send_pixel(corner[i]);
    // most fields at their extremes, to saturate the sums
    load_all('1, {32'h8000_0000, 32'h7FFF_FFFF}, '1, {32'h7FFF_FFFF, 32'h8000_0001},
             {32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
             64'd0, '1);
    foreach (corner[i]) send_pixel(corner[i]);
    // lower clamp above upper clamp, tiny w3 for a huge quotient
    load_all(64'd0, 64'd0, 64'd0, 64'd0, {32'h7FFF_0000, 32'd1},
             {32'h8000_0001, 32'd0}, 64'h7FFF_0000, 64'h0001_0000);
    send_pixel(corner[5]);
    send_pixel(corner[4]);
    settle();
    write_reg(REG_MIN_DEPTH, 64'd0);
    write_reg(REG_MAX_DEPTH, '1);
    // index beyond the register list is dropped
    write_reg(4'd8, '1);
    write_reg(4'd15, '1);
    send_pixel(corner[5]);
    send_pixel(corner[4]);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      random_geometry(ph % 4 == 3);
      sender_gaps = (ph != 2);
      stream_pixels(190);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    random_geometry(1'b0);
    hold_req = 1'b1;
    sender_gaps = 1'b0;
    stream_pixels(80);
    sender_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    stream_pixels(20);
    pause_sender(1);
    wait_for_results();
    stream_pixels(20);
  endtask

  task automatic test_full_rate();
    random_geometry(1'b0);
    quiet = 1'b1;
    stream_pixels(150);
  endtask

  initial begin
    geom = '0;
    geom.depth_hi = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    pause_sender(1);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
